### design/dcas_pkg.sv
// Package for the DMA channel address sequencer: item, result, state and
// configuration types, control bit positions and memory map constants.
// No dependencies.
`timescale 1ns / 1ps
package dcas_pkg;

  localparam int unsigned ADDR_W  = 28;
  localparam int unsigned CTRL_W  = 16;
  localparam int unsigned UNITS_W = 17;
  localparam int unsigned CNT_W   = 16;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_CTRL_WRITE = 2'd0,
    OP_TRIGGER    = 2'd1,
    OP_STEP       = 2'd2,
    OP_UNUSED     = 2'd3
  } dcas_op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SOURCE  = 2'd0,
    CFG_DEST    = 2'd1,
    CFG_COUNT   = 2'd2,
    CFG_CHANNEL = 2'd3
  } dcas_cfg_idx_t;

  localparam logic [1:0] CHAN_ZERO  = 2'd0;
  localparam logic [1:0] CHAN_THREE = 2'd3;

  // Control register bit positions
  localparam int unsigned BIT_DMODE_LO = 5;
  localparam int unsigned BIT_SMODE_LO = 7;
  localparam int unsigned BIT_REPEAT   = 9;
  localparam int unsigned BIT_WORD     = 10;
  localparam int unsigned BIT_TIMING_LO = 12;
  localparam int unsigned BIT_IRQ      = 14;
  localparam int unsigned BIT_ENABLE   = 15;

  // Address modes
  localparam logic [1:0] MODE_INC    = 2'd0;
  localparam logic [1:0] MODE_DEC    = 2'd1;
  localparam logic [1:0] MODE_RELOAD = 2'd3;

  // Writable control bits
  localparam logic [CTRL_W-1:0] WMASK_CH3   = 16'hFFE0;
  localparam logic [CTRL_W-1:0] WMASK_OTHER = 16'hF7E0;

  // High half masks for start addresses
  localparam logic [11:0] HI_MASK_NARROW = 12'h7FF;
  localparam logic [11:0] HI_MASK_WIDE   = 12'hFFF;

  // Count masks
  localparam logic [CNT_W-1:0] CNT_MASK_CH3   = 16'hFFFF;
  localparam logic [CNT_W-1:0] CNT_MASK_OTHER = 16'h3FFF;

  // Memory map bounds
  localparam logic [ADDR_W-1:0] XRAM_BASE = 28'h2000000;
  localparam logic [ADDR_W-1:0] ROM_BASE  = 28'h8000000;
  localparam logic [ADDR_W-1:0] SRAM_BASE = 28'hE000000;
  localparam logic [ADDR_W:0]   MEM_TOP   = 29'h10000000;

  localparam logic [ADDR_W-1:0] WORD_ALIGN = ~28'h3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CTRL_W-1:0] control_data;
    logic [CTRL_W-1:0] control_mask;
    logic [1:0]        trigger_event;
  } dcas_item_t;

  typedef struct packed {
    logic              bus_valid;
    logic [ADDR_W-1:0] read_address;
    logic [ADDR_W-1:0] write_address;
    logic              word_transfer;
    logic              reuse_latch;
    logic              sequential;
    logic              irq_request;
    logic              channel_active;
    logic [CTRL_W-1:0] control_value;
  } dcas_result_t;

  typedef struct packed {
    logic [CTRL_W-1:0]  control_bits;
    logic [ADDR_W-1:0]  source_pointer;
    logic [ADDR_W-1:0]  dest_pointer;
    logic [UNITS_W-1:0] units_left;
    logic               paused_flag;
    logic               starting_flag;
    logic               bad_source_flag;
  } dcas_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
    logic [CNT_W-1:0]  transfer_count;
    logic [1:0]        channel_number;
  } dcas_cfg_t;

endpackage

### design/dcas_in_if.sv
// Input channel interface: valid/ready plus the item fields.
// Depends on dcas_pkg.
`timescale 1ns / 1ps
interface dcas_in_if
  import dcas_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [CTRL_W-1:0] control_data;
  logic [CTRL_W-1:0] control_mask;
  logic [1:0]        trigger_event;

  modport source (output valid, operation, control_data, control_mask, trigger_event,
                  input ready);
  modport sink (input valid, operation, control_data, control_mask, trigger_event,
                output ready);
endinterface

### design/dcas_out_if.sv
// Result channel interface: valid/ready plus the result fields.
// Depends on dcas_pkg.
`timescale 1ns / 1ps
interface dcas_out_if
  import dcas_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              bus_valid;
  logic [ADDR_W-1:0] read_address;
  logic [ADDR_W-1:0] write_address;
  logic              word_transfer;
  logic              reuse_latch;
  logic              sequential;
  logic              irq_request;
  logic              channel_active;
  logic [CTRL_W-1:0] control_value;

  modport source (output valid, bus_valid, read_address, write_address, word_transfer,
                  reuse_latch, sequential, irq_request, channel_active, control_value,
                  input ready);
  modport sink (input valid, bus_valid, read_address, write_address, word_transfer,
                reuse_latch, sequential, irq_request, channel_active, control_value,
                output ready);
endinterface

### design/dcas_cfg_if.sv
// Configuration write channel interface: valid/ready, register index, data.
// Depends on dcas_pkg.
`timescale 1ns / 1ps
interface dcas_cfg_if
  import dcas_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [ADDR_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/dcas_cfg_regs.sv
// Configuration register bank: decodes writes and holds the start values.
// Depends on dcas_pkg.
`timescale 1ns / 1ps
module dcas_cfg_regs
  import dcas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [ADDR_W-1:0] wr_data,
  output dcas_cfg_t         cfg
);

  dcas_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (dcas_cfg_idx_t'(wr_index))
        CFG_SOURCE:  cfg_nxt.source_address = wr_data;
        CFG_DEST:    cfg_nxt.dest_address   = wr_data;
        CFG_COUNT:   cfg_nxt.transfer_count = wr_data[CNT_W-1:0];
        CFG_CHANNEL: cfg_nxt.channel_number = wr_data[1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/dcas_step.sv
// Next-state and result logic for one item: control write, trigger or step.
// Purely combinational. Depends on dcas_pkg.
`timescale 1ns / 1ps
module dcas_step
  import dcas_pkg::*;
(
  input  dcas_item_t   item,
  input  dcas_state_t  st,
  input  dcas_cfg_t    cfg,
  output dcas_state_t  st_nxt,
  output dcas_result_t res
);

  logic              is_ch0, is_ch3;
  logic [11:0]       src_hi, dst_hi;
  logic [ADDR_W-1:0] start_src, start_dst;
  logic [CNT_W-1:0]  cnt_mask, cnt_masked;
  logic [UNITS_W-1:0] reload_units;
  logic [CTRL_W-1:0] wmask, ctrl_wr;
  logic              word_now;
  logic [1:0]        smode, dmode;
  logic [ADDR_W-1:0] stride, sp, dp;
  logic [UNITS_W-1:0] units_dec;
  logic              src_rom;

  always_comb begin
    is_ch0 = (cfg.channel_number == CHAN_ZERO);
    is_ch3 = (cfg.channel_number == CHAN_THREE);
    src_hi = cfg.source_address[ADDR_W-1:16] & (is_ch0 ? HI_MASK_NARROW : HI_MASK_WIDE);
    dst_hi = cfg.dest_address[ADDR_W-1:16] & (is_ch3 ? HI_MASK_WIDE : HI_MASK_NARROW);
    start_src = {src_hi, cfg.source_address[15:0]};
    start_dst = {dst_hi, cfg.dest_address[15:0]};
    cnt_mask   = is_ch3 ? CNT_MASK_CH3 : CNT_MASK_OTHER;
    cnt_masked = cfg.transfer_count & cnt_mask;
    reload_units = (cnt_masked != '0) ? {1'b0, cnt_masked}
                                      : ({1'b0, cnt_mask} + UNITS_W'(1));
    wmask   = (is_ch3 ? WMASK_CH3 : WMASK_OTHER) & item.control_mask;
    ctrl_wr = (st.control_bits & ~wmask) | (item.control_data & wmask);

    word_now  = st.control_bits[BIT_WORD];
    smode     = st.control_bits[BIT_SMODE_LO +: 2];
    dmode     = st.control_bits[BIT_DMODE_LO +: 2];
    stride    = word_now ? ADDR_W'(4) : ADDR_W'(2);
    units_dec = st.units_left - UNITS_W'(1);
    src_rom   = (st.source_pointer >= ROM_BASE) && (st.source_pointer < SRAM_BASE);
    sp = st.source_pointer;
    dp = st.dest_pointer;

    st_nxt = st;
    res    = '0;

    case (dcas_op_t'(item.operation))
      OP_CTRL_WRITE: begin
        st_nxt.control_bits = ctrl_wr;
        // Rising edge of enable latches the start of a run
        if (!st.control_bits[BIT_ENABLE] && ctrl_wr[BIT_ENABLE]) begin
          st_nxt.bad_source_flag = (start_src < XRAM_BASE)
                                || ({1'b0, start_src} >= MEM_TOP)
                                || (is_ch0 && (start_src >= ROM_BASE));
          st_nxt.source_pointer = ctrl_wr[BIT_WORD] ? (start_src & WORD_ALIGN) : start_src;
          st_nxt.dest_pointer   = ctrl_wr[BIT_WORD] ? (start_dst & WORD_ALIGN) : start_dst;
          st_nxt.units_left     = reload_units;
          st_nxt.starting_flag  = 1'b1;
          st_nxt.paused_flag    = (ctrl_wr[BIT_TIMING_LO +: 2] != 2'd0);
        end
      end
      OP_TRIGGER: begin
        if (st.control_bits[BIT_ENABLE]
            && (st.control_bits[BIT_TIMING_LO +: 2] == item.trigger_event)) begin
          st_nxt.paused_flag = 1'b0;
        end
      end
      OP_STEP: begin
        if (st.control_bits[BIT_ENABLE] && !st.paused_flag) begin
          res.bus_valid     = 1'b1;
          res.read_address  = st.source_pointer;
          res.write_address = st.dest_pointer;
          res.word_transfer = word_now;
          res.reuse_latch   = st.bad_source_flag;
          res.sequential    = !st.starting_flag;
          st_nxt.starting_flag = 1'b0;

          // ROM sources always count upwards
          if (src_rom || (smode == MODE_INC)) begin
            sp = st.source_pointer + stride;
          end else if (smode == MODE_DEC) begin
            sp = st.source_pointer - stride;
          end
          if ((dmode == MODE_INC) || (dmode == MODE_RELOAD)) begin
            dp = st.dest_pointer + stride;
          end else if (dmode == MODE_DEC) begin
            dp = st.dest_pointer - stride;
          end
          st_nxt.source_pointer = sp;
          st_nxt.dest_pointer   = dp;
          st_nxt.units_left     = units_dec;

          if (units_dec == '0) begin
            res.irq_request = st.control_bits[BIT_IRQ];
            if (dmode == MODE_RELOAD) begin
              st_nxt.dest_pointer = word_now ? (start_dst & WORD_ALIGN) : start_dst;
            end
            if (st.control_bits[BIT_REPEAT]
                && (st.control_bits[BIT_TIMING_LO +: 2] != 2'd0)) begin
              st_nxt.units_left    = reload_units;
              st_nxt.starting_flag = 1'b1;
              st_nxt.paused_flag   = 1'b1;
            end else begin
              st_nxt.control_bits[BIT_ENABLE] = 1'b0;
            end
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase

    res.channel_active = st_nxt.control_bits[BIT_ENABLE] && !st_nxt.paused_flag;
    res.control_value  = st_nxt.control_bits;
  end

endmodule

### design/dma_channel_address_sequencer.sv
// DMA channel address sequencer, top level. One item a cycle unless the result
// side stalls, with an input register and a result register around the state
// update. Depends on dcas_pkg, the channel interfaces, dcas_cfg_regs and dcas_step.
`timescale 1ns / 1ps
// One DMA channel. Each input item is a control write, a trigger event or a
// transfer step, and gives exactly one result item: the addresses, width,
// sequential flag, latch reuse and irq request of the bus transfer issued
// (all zero when none), plus the channel's active flag and control value
// after the item. An item passes from acceptance through the input register,
// then the state update into the result register, and items follow back to
// back at one a cycle unless the result side stalls; the only loop is the
// channel state register, written in the same cycle as the result register.
// The input side stalls only when the result register is full and not being taken.
// Configuration registers (source, destination, count, channel number) are
// always ready and are applied when the enable bit rises or the count or
// destination is reloaded; write them only while the block is idle.
module dma_channel_address_sequencer
  import dcas_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dcas_in_if.sink   in_ch,
  dcas_out_if.source out_ch,
  dcas_cfg_if.sink  cfg_ch
);

  dcas_cfg_t    cfg;
  dcas_item_t   item_r;
  logic         in_valid_r;
  dcas_state_t  state_r, state_nxt;
  dcas_result_t res_nxt, res_r;
  logic         out_valid_r;
  logic         fire;      // stage 1 item moves into the result register
  logic         in_take;   // new item accepted into stage 1

  assign cfg_ch.ready = 1'b1;

  dcas_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  dcas_step u_step (
    .item   (item_r),
    .st     (state_r),
    .cfg    (cfg),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Result register frees up when empty or being taken this cycle
  assign fire     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || fire;
  assign in_take  = in_ch.valid && in_ch.ready;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.operation     <= in_ch.operation;
      item_r.control_data  <= in_ch.control_data;
      item_r.control_mask  <= in_ch.control_mask;
      item_r.trigger_event <= in_ch.trigger_event;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.bus_valid      = res_r.bus_valid;
  assign out_ch.read_address   = res_r.read_address;
  assign out_ch.write_address  = res_r.write_address;
  assign out_ch.word_transfer  = res_r.word_transfer;
  assign out_ch.reuse_latch    = res_r.reuse_latch;
  assign out_ch.sequential     = res_r.sequential;
  assign out_ch.irq_request    = res_r.irq_request;
  assign out_ch.channel_active = res_r.channel_active;
  assign out_ch.control_value  = res_r.control_value;

endmodule
